@@ sv/shuffled_batch_index_engine_assert.svh @@
// Assertion macros for the shuffled batch index engine.
// Included by the checker; needs nothing else.
`ifndef SHUFFLED_BATCH_INDEX_ENGINE_ASSERT_SVH
`define SHUFFLED_BATCH_INDEX_ENGINE_ASSERT_SVH

// Clocked assertion with explicit clock and active-low reset
`define SBIE_ASSERT_CR(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same, on the block clock and reset
`define SBIE_ASSERT(label, prop, msg) \
  `SBIE_ASSERT_CR(label, clk_i, rst_ni, prop, msg)

`endif

@@ sv/sbie_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants, codes and types of the shuffled batch index engine.
// No dependencies.
package sbie_pkg;

  // Table size and batch limit
  localparam int unsigned MAX_SAMPLES = 1024;
  localparam int unsigned MAX_BATCH   = 64;

  localparam int unsigned IDX_W = $clog2(MAX_SAMPLES);
  localparam int unsigned CNT_W = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned BAT_W = $clog2(MAX_BATCH + 1);

  // Field widths
  localparam int unsigned OP_W        = 2;
  localparam int unsigned SEED_W      = 32;
  localparam int unsigned ST_W        = 2;
  localparam int unsigned SIDX_W      = 10;
  localparam int unsigned NS_W        = 11;
  localparam int unsigned BS_W        = 7;
  localparam int unsigned TDATA_OUT_W = 16;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 11;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_SAMPLES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BATCH_LEN   = 2'd1;
  localparam logic [NS_W-1:0] NUM_SAMPLES_RST = 11'd1024;
  localparam logic [BS_W-1:0] BATCH_LEN_RST   = 7'd32;

  // Random generator
  localparam logic [SEED_W-1:0] DEFAULT_SEED = 32'd1234567891;
  localparam logic [SEED_W-1:0] LCG_MUL      = 32'd1664525;
  localparam logic [SEED_W-1:0] LCG_ADD      = 32'd1013904223;

  // Command queue between front and back (power of two)
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic [OP_W-1:0] {
    OP_SHUFFLE = 2'd0,
    OP_REWIND  = 2'd1,
    OP_BATCH   = 2'd2
  } op_e;

  typedef enum logic [ST_W-1:0] {
    ST_DONE  = 2'd0,
    ST_ITEM  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    op_e               op;
    logic [SEED_W-1:0] seed;
  } cmd_t;

  // Effective configuration, already saturated
  typedef struct packed {
    logic [CNT_W-1:0] n;
    logic [BAT_W-1:0] batch;
  } cfg_t;

endpackage

@@ sv/sbie_ram.sv @@
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sbie_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/sbie_divu.sv @@
`timescale 1ns / 1ps
// Bit-serial restoring remainder unit: 32-bit dividend by a table-sized divisor.
// Depends on sbie_pkg.
module sbie_divu import sbie_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [SEED_W-1:0] dividend_i,
  input  logic [CNT_W-1:0]  divisor_i,
  output logic              done_o,
  output logic [CNT_W-1:0]  rem_o
);

  localparam int unsigned STEP_W = $clog2(SEED_W);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [SEED_W-1:0] dvd_q, dvd_d;
  logic [CNT_W-1:0]  dsr_q, dsr_d;
  logic [CNT_W-1:0]  rem_q, rem_d;
  logic [CNT_W:0]    trial;
  logic [CNT_W:0]    diff;

  // One quotient bit per cycle, MSB first
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    dvd_d  = dvd_q;
    dsr_d  = dsr_q;
    rem_d  = rem_q;
    trial  = {rem_q, dvd_q[SEED_W-1]};
    diff   = trial - {1'b0, dsr_q};
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
      dvd_d  = dividend_i;
      dsr_d  = divisor_i;
      rem_d  = '0;
    end else if (busy_q) begin
      dvd_d  = {dvd_q[SEED_W-2:0], 1'b0};
      rem_d  = (trial >= {1'b0, dsr_q}) ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
      step_d = step_q + STEP_W'(1);
      if (step_q == STEP_W'(SEED_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dsr_q <= dsr_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

@@ sv/sbie_front.sv @@
`timescale 1ns / 1ps
// Front end: takes input beats, drops unknown opcodes, queues commands.
// Depends on sbie_pkg.
module sbie_front import sbie_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_valid_i,
  output logic              s_ready_o,
  input  logic [OP_W-1:0]   s_opcode_i,
  input  logic [SEED_W-1:0] s_seed_i,
  input  logic              init_done_i,
  output logic              cmd_valid_o,
  output cmd_t              cmd_o,
  input  logic              cmd_pop_i
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned FILL_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t              entry_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [FILL_W-1:0] fill_q, fill_d;
  logic              known_op;
  logic              push;
  logic              pop;

  // Classify the opcode; code three is taken and dropped
  always_comb begin
    unique case (s_opcode_i)
      OP_SHUFFLE, OP_REWIND, OP_BATCH: known_op = 1'b1;
      default:                         known_op = 1'b0;
    endcase
  end

  assign s_ready_o   = init_done_i && (fill_q != FILL_W'(QUEUE_DEPTH));
  assign push        = s_valid_i && s_ready_o && known_op;
  assign pop         = cmd_pop_i && (fill_q != '0);
  assign cmd_valid_o = (fill_q != '0);
  assign cmd_o       = entry_q[rd_ptr_q];

  // Queue pointers
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (push) begin
      wr_ptr_d = wr_ptr_q + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_d = rd_ptr_q + PTR_W'(1);
    end
    if (push && !pop) begin
      fill_d = fill_q + FILL_W'(1);
    end else if (pop && !push) begin
      fill_d = fill_q - FILL_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  // Queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= '{op: op_e'(s_opcode_i), seed: s_seed_i};
    end
  end

endmodule

@@ sv/sbie_back.sv @@
`timescale 1ns / 1ps
// Back end: table clearing pass, shuffle sequencer, batch reader, result register.
// Depends on sbie_pkg, sbie_ram and sbie_divu.
module sbie_back import sbie_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfg_t              cfg_i,
  input  logic              cmd_valid_i,
  input  cmd_t              cmd_i,
  output logic              cmd_pop_o,
  output logic              init_done_o,
  output logic              m_valid_o,
  input  logic              m_ready_i,
  output logic [ST_W-1:0]   m_status_o,
  output logic [SIDX_W-1:0] m_index_o,
  output logic              m_last_o
);

  localparam int unsigned STATE_W = 4;
  localparam logic [STATE_W-1:0] S_INIT  = 4'd0;
  localparam logic [STATE_W-1:0] S_IDLE  = 4'd1;
  localparam logic [STATE_W-1:0] S_LCG   = 4'd2;
  localparam logic [STATE_W-1:0] S_DIVS  = 4'd3;
  localparam logic [STATE_W-1:0] S_DIVW  = 4'd4;
  localparam logic [STATE_W-1:0] S_RDI   = 4'd5;
  localparam logic [STATE_W-1:0] S_RDJ   = 4'd6;
  localparam logic [STATE_W-1:0] S_WRI   = 4'd7;
  localparam logic [STATE_W-1:0] S_WRJ   = 4'd8;
  localparam logic [STATE_W-1:0] S_ACK   = 4'd9;
  localparam logic [STATE_W-1:0] S_EMPTY = 4'd10;
  localparam logic [STATE_W-1:0] S_BRD   = 4'd11;
  localparam logic [STATE_W-1:0] S_BOUT  = 4'd12;

  logic [STATE_W-1:0] state_q, state_d;
  logic [IDX_W-1:0]   init_addr_q, init_addr_d;
  logic [CNT_W-1:0]   cursor_q, cursor_d;
  logic [SEED_W-1:0]  lcg_q, lcg_d;
  logic [IDX_W-1:0]   i_q, i_d;
  logic [IDX_W-1:0]   j_q, j_d;
  logic [IDX_W-1:0]   ti_q, ti_d;
  logic [BAT_W-1:0]   left_q, left_d;
  logic               m_valid_q, m_valid_d;
  logic [ST_W-1:0]    m_status_q, m_status_d;
  logic [SIDX_W-1:0]  m_index_q, m_index_d;
  logic               m_last_q, m_last_d;

  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  logic [IDX_W-1:0]   mem_wdata;
  logic [IDX_W-1:0]   mem_raddr;
  logic [IDX_W-1:0]   mem_rdata;
  logic               div_start;
  logic               div_done;
  logic [CNT_W-1:0]   div_rem;
  logic               slot_free;
  logic [CNT_W-1:0]   remain;

  sbie_ram #(
    .WIDTH (IDX_W),
    .DEPTH (MAX_SAMPLES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  sbie_divu u_divu (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (lcg_q),
    .divisor_i  (CNT_W'(i_q) + CNT_W'(1)),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  assign slot_free = !m_valid_q || m_ready_i;
  assign remain    = cfg_i.n - cursor_q;

  // Sequencer
  always_comb begin
    state_d     = state_q;
    init_addr_d = init_addr_q;
    cursor_d    = cursor_q;
    lcg_d       = lcg_q;
    i_d         = i_q;
    j_d         = j_q;
    ti_d        = ti_q;
    left_d      = left_q;
    m_valid_d   = m_valid_q && !m_ready_i;
    m_status_d  = m_status_q;
    m_index_d   = m_index_q;
    m_last_d    = m_last_q;
    mem_we      = 1'b0;
    mem_waddr   = i_q;
    mem_wdata   = mem_rdata;
    mem_raddr   = IDX_W'(cursor_q);
    div_start   = 1'b0;
    cmd_pop_o   = 1'b0;

    unique case (state_q)
      // Identity fill after reset, one entry a cycle
      S_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = init_addr_q;
        mem_wdata = init_addr_q;
        init_addr_d = init_addr_q + IDX_W'(1);
        if (init_addr_q == IDX_W'(MAX_SAMPLES - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          unique case (cmd_i.op)
            OP_SHUFFLE: begin
              lcg_d = (cmd_i.seed == '0) ? DEFAULT_SEED : cmd_i.seed;
              if (cfg_i.n > CNT_W'(1)) begin
                i_d     = IDX_W'(cfg_i.n - CNT_W'(1));
                state_d = S_LCG;
              end else begin
                state_d = S_ACK;
              end
            end
            OP_REWIND: begin
              state_d = S_ACK;
            end
            OP_BATCH: begin
              if (cursor_q >= cfg_i.n) begin
                state_d = S_EMPTY;
              end else begin
                left_d  = (32'(remain) < 32'(cfg_i.batch)) ? BAT_W'(remain) : cfg_i.batch;
                state_d = S_BRD;
              end
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end
      // One shuffle step: advance generator, reduce, swap
      S_LCG: begin
        lcg_d   = lcg_q * LCG_MUL + LCG_ADD;
        state_d = S_DIVS;
      end
      S_DIVS: begin
        div_start = 1'b1;
        state_d   = S_DIVW;
      end
      S_DIVW: begin
        if (div_done) begin
          j_d     = IDX_W'(div_rem);
          state_d = S_RDI;
        end
      end
      S_RDI: begin
        mem_raddr = i_q;
        state_d   = S_RDJ;
      end
      S_RDJ: begin
        mem_raddr = j_q;
        ti_d      = mem_rdata;
        state_d   = S_WRI;
      end
      S_WRI: begin
        mem_we    = 1'b1;
        mem_waddr = i_q;
        mem_wdata = mem_rdata;
        state_d   = S_WRJ;
      end
      S_WRJ: begin
        mem_we    = 1'b1;
        mem_waddr = j_q;
        mem_wdata = ti_q;
        if (i_q == IDX_W'(1)) begin
          state_d = S_ACK;
        end else begin
          i_d     = i_q - IDX_W'(1);
          state_d = S_LCG;
        end
      end
      // Acknowledge shuffle or rewind; both leave the cursor at zero
      S_ACK: begin
        if (slot_free) begin
          m_valid_d  = 1'b1;
          m_status_d = ST_DONE;
          m_index_d  = '0;
          m_last_d   = 1'b1;
          cursor_d   = '0;
          state_d    = S_IDLE;
        end
      end
      S_EMPTY: begin
        if (slot_free) begin
          m_valid_d  = 1'b1;
          m_status_d = ST_EMPTY;
          m_index_d  = '0;
          m_last_d   = 1'b1;
          state_d    = S_IDLE;
        end
      end
      // Batch readout: address, then emit
      S_BRD: begin
        state_d = S_BOUT;
      end
      S_BOUT: begin
        if (slot_free) begin
          m_valid_d  = 1'b1;
          m_status_d = ST_ITEM;
          m_index_d  = SIDX_W'(mem_rdata);
          m_last_d   = (left_q == BAT_W'(1));
          cursor_d   = cursor_q + CNT_W'(1);
          left_d     = left_q - BAT_W'(1);
          state_d    = (left_q == BAT_W'(1)) ? S_IDLE : S_BRD;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      init_addr_q <= '0;
      cursor_q    <= '0;
      m_valid_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      init_addr_q <= init_addr_d;
      cursor_q    <= cursor_d;
      m_valid_q   <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lcg_q      <= lcg_d;
    i_q        <= i_d;
    j_q        <= j_d;
    ti_q       <= ti_d;
    left_q     <= left_d;
    m_status_q <= m_status_d;
    m_index_q  <= m_index_d;
    m_last_q   <= m_last_d;
  end

  assign init_done_o = (state_q != S_INIT);
  assign m_valid_o   = m_valid_q;
  assign m_status_o  = m_status_q;
  assign m_index_o   = m_index_q;
  assign m_last_o    = m_last_q;

endmodule

@@ sv/shuffled_batch_index_engine.sv @@
`timescale 1ns / 1ps
// Shuffled batch index engine: holds a 1024-entry permutation table and a read
// cursor. After reset a clearing pass loads the identity order; no beat is
// taken during it, though configuration writes are. A shuffle runs Fisher-Yates
// from the top entry down; each swap advances the generator, reduces it in the
// bit-serial remainder unit, then reads entry i, reads entry j and writes both
// back in the table, and the pass ends in a single acknowledge beat. A next-batch
// command streams up to the saturated batch length of indices, each beat waiting
// on the registered table read.
// Commands queue two deep in front of the sequencer, and the result register
// lets a finished beat wait on the output while the next command is taken.
// Depends on sbie_pkg, sbie_front, sbie_back.
module shuffled_batch_index_engine import sbie_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Command stream
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  logic [SEED_W-1:0]      s_axis_tdata_i,   // [31:0] seed
  input  logic [OP_W-1:0]        s_axis_tuser_i,   // [1:0] opcode
  // Result stream
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  output logic [TDATA_OUT_W-1:0] m_axis_tdata_o,   // [9:0] sample_index, [15:10] zero
  output logic [ST_W-1:0]        m_axis_tuser_o,   // [1:0] status
  output logic                   m_axis_tlast_o,   // last
  // Register writes
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i
);

  logic [NS_W-1:0]   num_samples_q, num_samples_d;
  logic [BS_W-1:0]   batch_len_q, batch_len_d;
  cfg_t              cfg;
  logic              init_done;
  logic              cmd_valid;
  cmd_t              cmd;
  logic              cmd_pop;
  logic [SIDX_W-1:0] out_index;

  // Register write decode; unknown indexes are dropped
  always_comb begin
    num_samples_d = num_samples_q;
    batch_len_d   = batch_len_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_NUM_SAMPLES: num_samples_d = NS_W'(cfg_data_i);
        REG_BATCH_LEN:   batch_len_d   = BS_W'(cfg_data_i);
        default: begin
          num_samples_d = num_samples_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_samples_q <= NUM_SAMPLES_RST;
      batch_len_q   <= BATCH_LEN_RST;
    end else begin
      num_samples_q <= num_samples_d;
      batch_len_q   <= batch_len_d;
    end
  end

  // Saturated working values
  always_comb begin
    cfg.n = (32'(num_samples_q) > 32'(MAX_SAMPLES)) ? CNT_W'(MAX_SAMPLES)
                                                     : CNT_W'(num_samples_q);
    if (batch_len_q == '0) begin
      cfg.batch = BAT_W'(1);
    end else if (32'(batch_len_q) > 32'(MAX_BATCH)) begin
      cfg.batch = BAT_W'(MAX_BATCH);
    end else begin
      cfg.batch = BAT_W'(batch_len_q);
    end
  end

  sbie_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_valid_i   (s_axis_tvalid_i),
    .s_ready_o   (s_axis_tready_o),
    .s_opcode_i  (s_axis_tuser_i),
    .s_seed_i    (s_axis_tdata_i),
    .init_done_i (init_done),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  sbie_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .init_done_o (init_done),
    .m_valid_o   (m_axis_tvalid_o),
    .m_ready_i   (m_axis_tready_i),
    .m_status_o  (m_axis_tuser_o),
    .m_index_o   (out_index),
    .m_last_o    (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = TDATA_OUT_W'(out_index);

endmodule

@@ sv/sbie_checker.sv @@
`timescale 1ns / 1ps
// Port-level checks on the result stream of the shuffled batch index engine.
// Depends on sbie_pkg and shuffled_batch_index_engine_assert.svh; bound to the top.
`include "shuffled_batch_index_engine_assert.svh"

module sbie_checker import sbie_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   m_axis_tvalid_o,
  input logic                   m_axis_tready_i,
  input logic [TDATA_OUT_W-1:0] m_axis_tdata_o,
  input logic [ST_W-1:0]        m_axis_tuser_o,
  input logic                   m_axis_tlast_o
);

  // Acknowledge and exhausted beats carry index zero
  `SBIE_ASSERT(a_status_zero_index, m_axis_tvalid_o && (m_axis_tuser_o != ST_ITEM) |-> (m_axis_tdata_o == '0), "status beat with nonzero index")

  // Acknowledge and exhausted beats are always single, so they close the run
  `SBIE_ASSERT(a_status_is_last, m_axis_tvalid_o && (m_axis_tuser_o != ST_ITEM) |-> m_axis_tlast_o, "status beat without last")

  // Emitted indices stay inside the table
  `SBIE_ASSERT(a_index_in_range, m_axis_tvalid_o && (m_axis_tuser_o == ST_ITEM) |-> (32'(m_axis_tdata_o) < 32'(MAX_SAMPLES)), "index beyond table")

  // A stalled beat holds
  `SBIE_ASSERT(a_stall_hold, m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o) && $stable(m_axis_tlast_o), "stalled beat changed")

endmodule

bind shuffled_batch_index_engine sbie_checker u_sbie_checker (.*);

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking bench for shuffled_batch_index_engine: an order tracker class
// predicts every result beat, and plain tasks drive commands and register writes.
// Depends on sbie_pkg and the engine RTL.

import sbie_pkg::*;

// One expected result beat
typedef struct packed {
  logic [ST_W-1:0]   status;
  logic [SIDX_W-1:0] sample_index;
  logic              last;
} result_beat_t;

// Tracks the permutation table and cursor, and holds the beats still owed
class shuffle_tracker;
  logic [SIDX_W-1:0] perm [MAX_SAMPLES];
  int unsigned       read_ptr;
  logic [NS_W-1:0]   num_samples;
  logic [BS_W-1:0]   batch_len;
  result_beat_t      pending_beats [$];
  int unsigned       errors;

  function new();
    for (int k = 0; k < MAX_SAMPLES; k++) perm[k] = SIDX_W'(k);
    read_ptr    = 0;
    num_samples = NUM_SAMPLES_RST;
    batch_len   = BATCH_LEN_RST;
    errors      = 0;
  endfunction

  function int unsigned active_count();
    return (num_samples > MAX_SAMPLES) ? MAX_SAMPLES : int'(num_samples);
  endfunction

  function int unsigned batch_limit();
    if (batch_len == 0) return 1;
    return (batch_len > MAX_BATCH) ? MAX_BATCH : int'(batch_len);
  endfunction

  function void owe(logic [ST_W-1:0] status, logic [SIDX_W-1:0] idx, logic last);
    result_beat_t b;
    b.status       = status;
    b.sample_index = idx;
    b.last         = last;
    pending_beats.push_back(b);
  endfunction

  function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    if (idx == REG_NUM_SAMPLES) num_samples = data[NS_W-1:0];
    else if (idx == REG_BATCH_LEN) batch_len = data[BS_W-1:0];
  endfunction

  // Fisher-Yates pass, top entry down to entry 1
  function void shuffle_table(logic [SEED_W-1:0] seed);
    logic [SEED_W-1:0] lcg;
    logic [SIDX_W-1:0] tmp;
    int unsigned       n;
    int unsigned       j;
    lcg = (seed == '0) ? DEFAULT_SEED : seed;
    n   = active_count();
    if (n > 0) begin
      for (int unsigned i = n - 1; i > 0; i--) begin
        lcg     = lcg * LCG_MUL + LCG_ADD;
        j       = lcg % (i + 1);
        tmp     = perm[i];
        perm[i] = perm[j];
        perm[j] = tmp;
      end
    end
  endfunction

  // Accepted command beat: update state, queue the beats it causes
  function void take_command(logic [OP_W-1:0] op, logic [SEED_W-1:0] seed);
    int unsigned n;
    int unsigned cnt;
    case (op)
      OP_SHUFFLE: begin
        shuffle_table(seed);
        read_ptr = 0;
        owe(ST_DONE, '0, 1'b1);
      end
      OP_REWIND: begin
        read_ptr = 0;
        owe(ST_DONE, '0, 1'b1);
      end
      OP_BATCH: begin
        n = active_count();
        if (read_ptr >= n) begin
          owe(ST_EMPTY, '0, 1'b1);
        end else begin
          cnt = batch_limit();
          if (n - read_ptr < cnt) cnt = n - read_ptr;
          for (int unsigned i = 0; i < cnt; i++)
            owe(ST_ITEM, perm[read_ptr + i], (i + 1 == cnt));
          read_ptr += cnt;
        end
      end
      default: ;  // unused opcode: no effect
    endcase
  endfunction

  // Accepted result beat: compare with the oldest expectation
  function void check_beat(logic [ST_W-1:0] status, logic [TDATA_OUT_W-1:0] data,
                           logic last);
    result_beat_t exp_b;
    logic [TDATA_OUT_W-1:0] exp_data;
    if (pending_beats.size() == 0) begin
      $display("%0t: unexpected result beat: status %0d, data %0d, last %0d",
               $time, status, data, last);
      errors++;
      return;
    end
    exp_b    = pending_beats.pop_front();
    exp_data = TDATA_OUT_W'(exp_b.sample_index);
    if (status !== exp_b.status) begin
      $display("%0t: status mismatch: expected %0d, actual %0d",
               $time, exp_b.status, status);
      errors++;
    end
    if (data !== exp_data) begin
      $display("%0t: sample index mismatch: expected %0d, actual %0d",
               $time, exp_data, data);
      errors++;
    end
    if (last !== exp_b.last) begin
      $display("%0t: last flag mismatch: expected %0d, actual %0d",
               $time, exp_b.last, last);
      errors++;
    end
  endfunction
endclass

module testbench;

  localparam int unsigned RESET_CYCLES = 11;
  localparam int unsigned TAIL_CYCLES  = 64;
  localparam int unsigned CYCLE_LIMIT  = 3000000;
  localparam int unsigned RANDOM_ITEMS = 70;

  // Codes outside the defined sets
  localparam logic [OP_W-1:0]      OP_UNUSED    = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_3 = 2'd3;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid_i = 1'b0;
  logic                   s_axis_tready_o;
  logic [SEED_W-1:0]      s_axis_tdata_i = '0;
  logic [OP_W-1:0]        s_axis_tuser_i = '0;
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i = 1'b0;
  logic [TDATA_OUT_W-1:0] m_axis_tdata_o;
  logic [ST_W-1:0]        m_axis_tuser_o;
  logic                   m_axis_tlast_o;
  logic                   cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i = '0;

  shuffle_tracker trk;
  int unsigned    burst_left = 0;
  int unsigned    ready_left = 0;
  logic           ready_val = 1'b0;

  shuffled_batch_index_engine dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i)
  );

  // 12 ns clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Result side: check each accepted beat, stall on runs of random length
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i)
      trk.check_beat(m_axis_tuser_o, m_axis_tdata_o, m_axis_tlast_o);
    if (ready_left == 0) begin
      if ($urandom_range(0, 9) == 0) begin
        ready_val  = 1'b1;
        ready_left = $urandom_range(100, 300);
      end else begin
        ready_val  = ($urandom_range(0, 3) != 0);
        ready_left = $urandom_range(1, 12);
      end
    end else begin
      ready_left--;
    end
    m_axis_tready_i <= ready_val;
  end

  // Watchdog
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("shuffled_batch_index_engine test failed");
    $finish;
  end

  // One command beat, sent in bursts with random gaps between them
  task automatic send_cmd(input logic [OP_W-1:0] op, input logic [SEED_W-1:0] seed);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap != 0) begin
        s_axis_tvalid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40)
                                               : $urandom_range(1, 6);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= seed;
    s_axis_tuser_i  <= op;
    do @(posedge clk_i); while (!s_axis_tready_o);
    trk.take_command(op, seed);
    burst_left--;
  endtask

  // Stop sending, let every owed beat arrive, then let the engine go quiet
  task automatic settle();
    s_axis_tvalid_i <= 1'b0;
    while (trk.pending_beats.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    trk.set_reg(idx, data);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_config(input int unsigned ns, input int unsigned bs);
    write_reg(REG_NUM_SAMPLES, CFG_DATA_W'(ns));
    write_reg(REG_BATCH_LEN, CFG_DATA_W'(bs));
  endtask

  initial begin
    logic [OP_W-1:0]   op;
    logic [SEED_W-1:0] seed;
    int unsigned       pick;
    int unsigned       ns;
    int unsigned       bs;
    int unsigned       phase_len;
    int unsigned       items_done;

    trk = new();
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset configuration: identity order, cursor movement, unused opcode
    send_cmd(OP_BATCH, $urandom());
    send_cmd(OP_UNUSED, $urandom());
    send_cmd(OP_BATCH, $urandom());
    send_cmd(OP_REWIND, $urandom());
    send_cmd(OP_BATCH, $urandom());
    settle();

    // Both registers saturate; writes past the register list are dropped
    set_config(11'h7FF, 7'h7F);
    write_reg(REG_UNUSED_2, 11'h7FF);
    write_reg(REG_UNUSED_3, CFG_DATA_W'($urandom()));
    send_cmd(OP_SHUFFLE, 32'h0000_0000);
    send_cmd(OP_BATCH, $urandom());
    send_cmd(OP_SHUFFLE, 32'hFFFF_FFFF);
    send_cmd(OP_BATCH, $urandom());
    settle();

    // Zero samples and zero batch length
    set_config(0, 0);
    send_cmd(OP_SHUFFLE, $urandom());
    send_cmd(OP_BATCH, $urandom());
    send_cmd(OP_REWIND, $urandom());
    send_cmd(OP_BATCH, $urandom());
    settle();

    // Single sample, single-entry batches
    set_config(1, 1);
    send_cmd(OP_BATCH, $urandom());
    send_cmd(OP_BATCH, $urandom());
    send_cmd(OP_SHUFFLE, $urandom());
    send_cmd(OP_BATCH, $urandom());
    settle();

    // Short final batch, then exhausted, then rewind
    set_config(5, 2);
    send_cmd(OP_BATCH, $urandom());
    send_cmd(OP_BATCH, $urandom());
    send_cmd(OP_BATCH, $urandom());
    send_cmd(OP_BATCH, $urandom());
    send_cmd(OP_REWIND, $urandom());
    send_cmd(OP_BATCH, $urandom());
    settle();

    // Random phases: mostly small tables so shuffles stay short
    items_done = 0;
    while (items_done < RANDOM_ITEMS) begin
      ns = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 2047) : $urandom_range(1, 40);
      bs = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 12);
      set_config(ns, bs);
      if ($urandom_range(0, 7) == 0)
        write_reg($urandom_range(0, 1) ? REG_UNUSED_2 : REG_UNUSED_3,
                  CFG_DATA_W'($urandom()));
      phase_len = $urandom_range(6, 16);
      for (int k = 0; k < phase_len; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 5)
          op = OP_UNUSED;
        else if (pick < 20 && (ns <= 64 || pick < 7))
          op = OP_SHUFFLE;
        else if (pick < 30)
          op = OP_REWIND;
        else
          op = OP_BATCH;
        seed = ($urandom_range(0, 15) == 0) ? '0 : $urandom();
        send_cmd(op, seed);
        if (op != OP_UNUSED) items_done++;
      end
      settle();
    end

    if (trk.errors == 0 && trk.pending_beats.size() == 0)
      $display("shuffled_batch_index_engine test passed");
    else
      $display("shuffled_batch_index_engine test failed");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+sv
sv/sbie_pkg.sv
sv/sbie_ram.sv
sv/sbie_divu.sv
sv/sbie_front.sv
sv/sbie_back.sv
sv/shuffled_batch_index_engine.sv
sv/sbie_checker.sv
tb/testbench.sv
